// ===== design/sil_pkg.sv =====
// Shared constants, codes and types for the sorted id list engine.
package sil_pkg;

    localparam int CAPACITY = 64;
    localparam int ID_WIDTH = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_FIND   = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    typedef logic [ID_WIDTH-1:0] t_id;

    // Compare results latched by each cell, already qualified by the cell being occupied.
    typedef struct packed {
        logic gt;
        logic ge;
        logic eq;
    } t_cell_flags;

    // Update strobes broadcast to every cell.
    typedef struct packed {
        logic cmp;
        logic ins;
        logic rem;
    } t_cell_ctl;

endpackage

// ===== design/sorted_id_list_engine.sv =====
// Top level of the sorted id list engine: request control, count and a row of list cells.
//
// Usage: drive i_kind (0 insert, 1 remove, 2 find) and i_key_id with start high; the
// request transfers at a rising edge where start is high and busy is low.
// After the transfer edge latches a request, the S_CMP state latches every cell's
// compare flags and the S_UPD state shifts the row of cells and updates the
// count. The result (o_status, o_match_id, o_entry_count) is shown for exactly one
// cycle with o_done high, in the cycle right after the update edge; busy is already
// low then, so a new request may transfer in that cycle. No new request is taken
// while busy is high, during the compare and update passes over the cells.
// An insert lands before the first entry greater than the key; a remove drops the
// first equal entry; an insert into a full list is dropped with status full.
// Kind 3 is a no-op that reports not found.
// Reset (i_rst_n low, synchronous) empties the list and clears busy and o_done; entry
// contents are not cleared, only entries below the count are ever used.
// The receiver cannot stall: every result transfers in the cycle it is shown.
module sorted_id_list_engine (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [1:0]                 i_kind,
    input  logic [sil_pkg::ID_WIDTH-1:0] i_key_id,
    output logic                       o_done,
    output logic [1:0]                 o_status,
    output logic [31:0]                o_match_id,
    output logic [sil_pkg::CNT_W-1:0]  o_entry_count
);
    import sil_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [1:0]       r_kind;
    t_id              r_key;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_done;
    logic [1:0]       r_status, n_status;
    logic [31:0]      r_match, n_match;

    t_id          entry [CAPACITY];
    t_cell_flags  flags [CAPACITY];
    logic [CAPACITY-1:0] eq_vec;
    logic         hit, full, accept;
    t_cell_ctl    ctl;

    assign accept = start && (r_state == S_IDLE);
    assign full   = (r_count == CNT_W'(CAPACITY));
    assign hit    = |eq_vec;

    always_comb begin
        ctl.cmp = (r_state == S_CMP);
        ctl.ins = (r_state == S_UPD) && (r_kind == KIND_INSERT) && !full;
        ctl.rem = (r_state == S_UPD) && (r_kind == KIND_REMOVE) && hit;
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_id  left_entry, right_entry;
        logic left_gt;
        if (g == 0) begin : g_first
            assign left_entry = r_key;
            assign left_gt    = 1'b0;
        end else begin : g_mid
            assign left_entry = entry[g-1];
            assign left_gt    = flags[g-1].gt;
        end
        if (g == CAPACITY - 1) begin : g_last
            assign right_entry = r_key;
        end else begin : g_inner
            assign right_entry = entry[g+1];
        end
        assign eq_vec[g] = flags[g].eq;

        sil_cell u_cell (
            .i_clk         (i_clk),
            .i_ctl         (ctl),
            .i_key         (r_key),
            .i_valid       (CNT_W'(g) < r_count),
            .i_tail        (CNT_W'(g) == r_count),
            .i_left_entry  (left_entry),
            .i_left_gt     (left_gt),
            .i_right_entry (right_entry),
            .o_entry       (entry[g]),
            .o_flags       (flags[g])
        );
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_status = ST_NOT_FOUND;
        n_match  = '0;
        case (r_state)
            S_IDLE: if (accept) n_state = S_CMP;
            S_CMP:  n_state = S_UPD;
            S_UPD: begin
                n_state = S_IDLE;
                case (r_kind)
                    KIND_INSERT: begin
                        if (full) begin
                            n_status = ST_FULL;
                        end else begin
                            n_status = ST_OK;
                            n_count  = r_count + 1'b1;
                        end
                    end
                    KIND_REMOVE: begin
                        if (hit) begin
                            n_status = ST_OK;
                            n_count  = r_count - 1'b1;
                        end
                    end
                    KIND_FIND: begin
                        if (hit) begin
                            n_status = ST_OK;
                            n_match  = 32'(r_key);
                        end
                    end
                    default: n_status = ST_NOT_FOUND;
                endcase
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= (r_state == S_UPD);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind <= i_kind;
            r_key  <= i_key_id;
        end
        if (r_state == S_UPD) begin
            r_status <= n_status;
            r_match  <= n_match;
        end
    end

    assign busy          = (r_state != S_IDLE);
    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_match_id    = r_match;
    assign o_entry_count = r_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("count above capacity");

    a_done_after_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == S_UPD))
        else $error("result without update pass");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy ##1 busy)
        else $error("busy dropped during request");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_FULL) |-> (o_entry_count == CNT_W'(CAPACITY)))
        else $error("full reported below capacity");

    a_match_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_match_id != '0) |-> (o_status == ST_OK))
        else $error("match id on failed request");

endmodule

// ===== design/sil_cell.sv =====
// One slot of the sorted list: compares against the key and shifts with its neighbors.
module sil_cell (
    input  logic                 i_clk,
    input  sil_pkg::t_cell_ctl   i_ctl,
    input  sil_pkg::t_id         i_key,
    input  logic                 i_valid,
    input  logic                 i_tail,
    input  sil_pkg::t_id         i_left_entry,
    input  logic                 i_left_gt,
    input  sil_pkg::t_id         i_right_entry,
    output sil_pkg::t_id         o_entry,
    output sil_pkg::t_cell_flags o_flags
);
    import sil_pkg::*;

    t_id         r_entry, n_entry;
    t_cell_flags r_flags, n_flags;

    always_comb begin
        n_flags    = r_flags;
        n_entry    = r_entry;
        if (i_ctl.cmp) begin
            n_flags.gt = i_valid && (r_entry > i_key);
            n_flags.ge = i_valid && (r_entry >= i_key);
            n_flags.eq = i_valid && (r_entry == i_key);
        end
        if (i_ctl.ins) begin
            if (i_left_gt) begin
                n_entry = i_left_entry;
            end else if (r_flags.gt || i_tail) begin
                n_entry = i_key;
            end
        end else if (i_ctl.rem) begin
            if (r_flags.ge) begin
                n_entry = i_right_entry;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        r_flags <= n_flags;
    end

    assign o_entry = r_entry;
    assign o_flags = r_flags;

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for sorted_id_list_engine: shadow list predictor, mixed traffic.
`timescale 1ns / 100ps

module tb_top;
    import sil_pkg::*;

    localparam logic [1:0] KIND_NOOP = 2'd3;
    localparam int WATCHDOG_LIMIT = 500;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        logic [1:0]       status;
        logic [31:0]      match_id;
        logic [CNT_W-1:0] count;
    } t_list_result;

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    logic [1:0]       i_kind;
    t_id              i_key_id;
    logic             o_done;
    logic [1:0]       o_status;
    logic [31:0]      o_match_id;
    logic [CNT_W-1:0] o_entry_count;

    t_id          shadow_list[$];
    t_list_result pending_results[$];
    int           idle_pct;
    int           mismatches;
    int           stall_cycles;
    int           kind_seen[4];
    int           status_seen[4];
    int           peak_depth;

    sorted_id_list_engine i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_kind        (i_kind),
        .i_key_id      (i_key_id),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_match_id    (o_match_id),
        .o_entry_count (o_entry_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_list_result apply_to_shadow_list(input logic [1:0] kind, input t_id key);
        t_list_result res;
        int pos;
        res.status   = ST_NOT_FOUND;
        res.match_id = '0;
        pos = -1;
        case (kind)
            KIND_INSERT: begin
                if (shadow_list.size() >= CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    pos = shadow_list.size();
                    for (int i = 0; i < shadow_list.size(); i++) begin
                        if (key < shadow_list[i]) begin
                            pos = i;
                            break;
                        end
                    end
                    shadow_list.insert(pos, key);
                    res.status = ST_OK;
                end
            end
            KIND_REMOVE, KIND_FIND: begin
                for (int i = 0; i < shadow_list.size(); i++) begin
                    if (shadow_list[i] == key) begin
                        pos = i;
                        break;
                    end
                end
                if (pos >= 0) begin
                    res.status = ST_OK;
                    if (kind == KIND_FIND) begin
                        res.match_id = 32'(shadow_list[pos]);
                    end else begin
                        shadow_list.delete(pos);
                    end
                end
            end
            default: ;
        endcase
        res.count = CNT_W'(shadow_list.size());
        return res;
    endfunction

    function automatic t_id pick_key();
        int r;
        r = $urandom_range(99);
        if (r < 40 && shadow_list.size() > 0) begin
            return shadow_list[$urandom_range(shadow_list.size() - 1)];
        end else if (r < 70) begin
            return t_id'($urandom_range(15));
        end else if (r < 80) begin
            case ($urandom_range(3))
                0: return 32'h0000_0000;
                1: return 32'hFFFF_FFFF;
                2: return 32'h8000_0000;
                default: return 32'h7FFF_FFFF;
            endcase
        end
        return t_id'($urandom);
    endfunction

    function automatic logic [1:0] pick_kind(input int insert_bias);
        if ($urandom_range(99) < 3) begin
            return KIND_NOOP;
        end else if ($urandom_range(99) < insert_bias) begin
            return KIND_INSERT;
        end else if ($urandom_range(1) == 0) begin
            return KIND_REMOVE;
        end
        return KIND_FIND;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_request(input logic [1:0] kind, input t_id key);
        t_list_result res;
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start    <= 1'b1;
        i_kind   <= kind;
        i_key_id <= key;
        do begin
            @(posedge i_clk);
        end while (busy !== 1'b0);
        res = apply_to_shadow_list(kind, key);
        pending_results.insert(pending_results.size(), res);
        kind_seen[kind]++;
        status_seen[res.status]++;
        if (shadow_list.size() > peak_depth) begin
            peak_depth = shadow_list.size();
        end
        @(negedge i_clk);
    endtask

    task automatic test_edge_requests();
        idle_pct = 0;
        send_request(KIND_FIND,   32'h0000_0000);
        send_request(KIND_REMOVE, 32'h0000_0005);
        send_request(KIND_NOOP,   32'hFFFF_FFFF);
        send_request(KIND_INSERT, 32'hFFFF_FFFF);
        send_request(KIND_INSERT, 32'h0000_0000);
        send_request(KIND_INSERT, 32'h8000_0000);
        send_request(KIND_INSERT, 32'h8000_0000);
        send_request(KIND_INSERT, 32'h7FFF_FFFF);
        send_request(KIND_FIND,   32'hFFFF_FFFF);
        send_request(KIND_FIND,   32'h0000_0000);
        send_request(KIND_FIND,   32'h0000_0001);
        send_request(KIND_REMOVE, 32'h8000_0000);
        send_request(KIND_FIND,   32'h8000_0000);
        send_request(KIND_REMOVE, 32'h8000_0000);
        send_request(KIND_REMOVE, 32'h8000_0000);
        send_request(KIND_NOOP,   32'h0000_0000);
        send_request(KIND_REMOVE, 32'h0000_0000);
        send_request(KIND_REMOVE, 32'hFFFF_FFFF);
        send_request(KIND_REMOVE, 32'h7FFF_FFFF);
        send_request(KIND_INSERT, 32'h5A5A_5A5A);
        send_request(KIND_FIND,   32'hA5A5_A5A5);
        send_request(KIND_REMOVE, 32'h5A5A_5A5A);
    endtask

    task automatic test_fill_to_capacity();
        idle_pct = 16;
        while (shadow_list.size() < CAPACITY) begin
            send_request(KIND_INSERT, pick_key());
        end
        send_request(KIND_INSERT, 32'h0000_0000);
        send_request(KIND_INSERT, 32'hFFFF_FFFF);
        send_request(KIND_FIND, shadow_list[CAPACITY - 1]);
        send_request(KIND_NOOP, shadow_list[0]);
        send_request(KIND_REMOVE, shadow_list[CAPACITY - 1]);
        send_request(KIND_INSERT, t_id'($urandom));
        send_request(KIND_INSERT, t_id'($urandom));
        while (shadow_list.size() > 0) begin
            send_request(KIND_REMOVE, shadow_list[$urandom_range(shadow_list.size() - 1)]);
        end
        send_request(KIND_FIND, 32'h0000_0000);
    endtask

    task automatic test_random_traffic(input int sender_idle, input int n_items);
        int sent;
        int seg_left;
        int insert_bias;
        idle_pct    = sender_idle;
        sent        = 0;
        seg_left    = 0;
        insert_bias = 50;
        while (sent < n_items) begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(120, 40);
                case ($urandom_range(2))
                    0: insert_bias = 80;
                    1: insert_bias = 50;
                    default: insert_bias = 20;
                endcase
            end
            send_request(pick_kind(insert_bias), pick_key());
            seg_left--;
            sent++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_done === 1'b1) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("%0t: result transfer with nothing pending %s",
                             $realtime, "(see status, id and count below)");
                    $display("    status %0d id %h count %0d",
                             o_status, o_match_id, o_entry_count);
                end
            end else begin
                t_list_result exp_res;
                exp_res = pending_results.pop_front();
                if (o_status !== exp_res.status || o_match_id !== exp_res.match_id
                        || o_entry_count !== exp_res.count) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("%0t: status exp %0d got %0d, match_id exp %h got %h,",
                                 $realtime, exp_res.status, o_status, exp_res.match_id,
                                 o_match_id);
                        $display("    count exp %0d got %0d",
                                 exp_res.count, o_entry_count);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start === 1'b1 && busy === 1'b0) || o_done === 1'b1) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d results pending",
                     stall_cycles, pending_results.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_kind       = KIND_INSERT;
        i_key_id     = '0;
        idle_pct     = 0;
        mismatches   = 0;
        stall_cycles = 0;
        peak_depth   = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_edge_requests();
        test_fill_to_capacity();
        test_random_traffic(0, 470);
        test_random_traffic(57, 470);
        test_random_traffic(16, 470);
        start <= 1'b0;

        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (6) @(posedge i_clk);
        mismatches += pending_results.size();

        $display("covered %0d inserts, %0d removes, %0d finds, %0d no-op kinds",
                 kind_seen[KIND_INSERT], kind_seen[KIND_REMOVE], kind_seen[KIND_FIND],
                 kind_seen[KIND_NOOP]);
        $display("outcomes: %0d ok, %0d not found, %0d full drops; peak depth %0d of %0d",
                 status_seen[ST_OK], status_seen[ST_NOT_FOUND], status_seen[ST_FULL],
                 peak_depth, CAPACITY);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
